@@ rtl/cdc_pkg.sv @@
`default_nettype none
package cdc_pkg;

	localparam int MAX_TAPS_DEF    = 32;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int ACC_W           = 38;
	localparam int TAP_INDEX_W     = 5;
	localparam int XLEN_W          = 6;
	localparam int QUEUE_DEPTH     = 2;
	localparam int APB_DATA_W      = 32;
	localparam int APB_ADDR_W      = 2;

	localparam logic [APB_ADDR_W-1:0] REG_X_LENGTH = 2'd0;
	localparam logic [XLEN_W-1:0]     XLEN_RESET   = 6'd1;

	typedef enum logic [1:0] {
		CMD_TAP,
		CMD_SAMPLE,
		CMD_FINAL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [TAP_INDEX_W-1:0] tap_index;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		logic busy;
		logic flushing;
		logic hist_empty;
	} back_stat_t;

endpackage
`default_nettype wire

@@ rtl/cdc_in_if.sv @@
`default_nettype none
interface cdc_in_if #(
	parameter int SAMPLE_BITS = cdc_pkg::SAMPLE_BITS_DEF
);
	logic                                 valid;
	logic                                 ready;
	logic                                 action;
	logic [cdc_pkg::TAP_INDEX_W-1:0]      tap_index;
	logic signed [SAMPLE_BITS-1:0]        sample_re;
	logic signed [SAMPLE_BITS-1:0]        sample_im;
	logic                                 is_final;

	modport source (
		output valid, action, tap_index, sample_re, sample_im, is_final,
		input  ready
	);
	modport sink (
		input  valid, action, tap_index, sample_re, sample_im, is_final,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/cdc_out_if.sv @@
`default_nettype none
interface cdc_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [cdc_pkg::ACC_W-1:0] out_re;
	logic signed [cdc_pkg::ACC_W-1:0] out_im;
	logic                             run_end;

	modport source (
		output valid, out_re, out_im, run_end,
		input  ready
	);
	modport sink (
		input  valid, out_re, out_im, run_end,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/cdc_front.sv @@
`default_nettype none
module cdc_front #(
	parameter int MAX_TAPS    = cdc_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = cdc_pkg::SAMPLE_BITS_DEF,
	parameter int QW          = $bits(cdc_pkg::cmd_t) + 2 * SAMPLE_BITS
) (
	cdc_in_if.sink         in_ch,
	output logic           push_valid,
	input  wire            push_ready,
	output logic [QW-1:0]  push_data
);
	cdc_pkg::cmd_t cmd;
	logic          drop;

	always_comb begin
		cmd.tap_index = in_ch.tap_index;
		if (!in_ch.action) begin
			cmd.kind = cdc_pkg::CMD_TAP;
		end else if (in_ch.is_final) begin
			cmd.kind = cdc_pkg::CMD_FINAL;
		end else begin
			cmd.kind = cdc_pkg::CMD_SAMPLE;
		end
	end

	// tap writes past the table are taken and thrown away
	assign drop       = !in_ch.action && (int'(in_ch.tap_index) >= MAX_TAPS);
	assign in_ch.ready = push_ready;
	assign push_valid  = in_ch.valid && !drop;
	assign push_data   = {cmd, in_ch.sample_re, in_ch.sample_im};
endmodule
`default_nettype wire

@@ rtl/cdc_queue.sv @@
`default_nettype none
module cdc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = cdc_pkg::QUEUE_DEPTH
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_ready,
	input  wire [WIDTH-1:0]  push_data,
	output logic             pop_valid,
	input  wire              pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [NW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != NW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/cdc_back.sv @@
`default_nettype none
module cdc_back #(
	parameter int MAX_TAPS    = cdc_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = cdc_pkg::SAMPLE_BITS_DEF,
	parameter int QW          = $bits(cdc_pkg::cmd_t) + 2 * SAMPLE_BITS,
	parameter int CW          = $clog2(MAX_TAPS + 1)
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire [CW-1:0]        m,
	input  wire                 q_valid,
	output logic                q_ready,
	input  wire [QW-1:0]        q_data,
	cdc_out_if.source           res,
	output cdc_pkg::back_stat_t stat
);
	localparam int SB    = SAMPLE_BITS;
	localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int ACC_W = cdc_pkg::ACC_W;
	localparam int EXT_W = (2 * SB > ACC_W) ? 2 * SB : ACC_W;

	cdc_pkg::back_state_t state_q, state_d;
	cdc_pkg::cmd_t        cmd;
	logic [SB-1:0]        q_re, q_im;

	logic [2*SB-1:0] tap_mem  [MAX_TAPS];
	logic [2*SB-1:0] hist_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0] tap_valid_q;

	logic [AW-1:0] wp_q, wp_nx, tap_addr, k_addr, hist_addr;
	logic [AW:0]   hist_diff;
	logic [CW-1:0] k_q, hcnt_q, hcnt_nx, tail_q;
	logic          fin_q;

	logic pop, tap_we, push, push_zero, iss, last_iss, load, out_free;
	logic [2*SB-1:0] hist_wdata;

	logic            v_s1, last_s1, v_s2, last_s2;
	logic [2*SB-1:0] tap_rd_s1, hist_rd_s1;
	logic            tv_s1, hv_s1;
	logic signed [SB-1:0] tr, ti, hr, hi;
	logic signed [2*SB-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [EXT_W-1:0] e_rr, e_ii, e_ri, e_ir;
	logic [ACC_W-1:0] acc_re_q, acc_im_q;

	logic             out_valid_q, out_end_q;
	logic [ACC_W-1:0] out_re_q, out_im_q;

	assign cmd  = cdc_pkg::cmd_t'(q_data[QW-1:2*SB]);
	assign q_re = q_data[2*SB-1:SB];
	assign q_im = q_data[SB-1:0];

	assign tap_addr = AW'(cmd.tap_index);
	assign k_addr   = k_q[AW-1:0];
	assign last_iss = (k_q == m - CW'(1));
	assign out_free = !out_valid_q || res.ready;
	assign wp_nx    = (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + AW'(1);
	assign hcnt_nx  = (hcnt_q == CW'(MAX_TAPS)) ? hcnt_q : hcnt_q + CW'(1);

	// newest sample sits at wp, older ones behind it around the ring
	assign hist_diff = {1'b0, wp_q} - {1'b0, k_addr};
	assign hist_addr = hist_diff[AW] ? AW'(hist_diff + (AW + 1)'(MAX_TAPS))
		: hist_diff[AW-1:0];

	assign hist_wdata = push_zero ? '0 : {q_re, q_im};

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		tap_we    = 1'b0;
		push      = 1'b0;
		push_zero = 1'b0;
		iss       = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			cdc_pkg::ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					unique case (cmd.kind)
						cdc_pkg::CMD_TAP: tap_we = 1'b1;
						cdc_pkg::CMD_SAMPLE, cdc_pkg::CMD_FINAL: begin
							push    = 1'b1;
							state_d = cdc_pkg::ST_MAC;
						end
						default: ;
					endcase
				end
			end
			cdc_pkg::ST_MAC: begin
				iss = 1'b1;
				if (last_iss) begin
					state_d = cdc_pkg::ST_DRAIN;
				end
			end
			cdc_pkg::ST_DRAIN: begin
				if (v_s2 && last_s2) begin
					state_d = cdc_pkg::ST_EMIT;
				end
			end
			cdc_pkg::ST_EMIT: begin
				if (out_free) begin
					load = 1'b1;
					if (tail_q != '0) begin
						push      = 1'b1;
						push_zero = 1'b1;
						state_d   = cdc_pkg::ST_MAC;
					end else begin
						state_d = cdc_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = cdc_pkg::ST_IDLE;
		endcase
	end

	assign q_ready = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cdc_pkg::ST_IDLE;
			tap_valid_q <= '0;
			wp_q        <= '0;
			hcnt_q      <= '0;
			k_q         <= '0;
			tail_q      <= '0;
			fin_q       <= 1'b0;
			v_s1        <= 1'b0;
			last_s1     <= 1'b0;
			v_s2        <= 1'b0;
			last_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tap_we) begin
				tap_valid_q[tap_addr] <= 1'b1;
			end
			if (push) begin
				wp_q   <= wp_nx;
				hcnt_q <= hcnt_nx;
				k_q    <= '0;
			end else if (iss) begin
				k_q <= k_q + CW'(1);
			end
			if (push && !push_zero) begin
				fin_q  <= (cmd.kind == cdc_pkg::CMD_FINAL);
				tail_q <= (cmd.kind == cdc_pkg::CMD_FINAL) ? m - CW'(1) : '0;
			end else if (push) begin
				tail_q <= tail_q - CW'(1);
			end
			// end of a flush empties the history
			if (load && tail_q == '0 && fin_q) begin
				hcnt_q <= '0;
			end
			v_s1    <= iss;
			last_s1 <= iss && last_iss;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hist_mem[wp_nx] <= hist_wdata;
		end
		if (tap_we) begin
			tap_mem[tap_addr] <= {q_re, q_im};
		end
		hist_rd_s1 <= hist_mem[hist_addr];
		tap_rd_s1  <= tap_mem[k_addr];
		tv_s1      <= tap_valid_q[k_addr];
		hv_s1      <= (k_q < hcnt_q);
	end

	assign tr = tv_s1 ? tap_rd_s1[2*SB-1:SB] : '0;
	assign ti = tv_s1 ? tap_rd_s1[SB-1:0] : '0;
	assign hr = hv_s1 ? hist_rd_s1[2*SB-1:SB] : '0;
	assign hi = hv_s1 ? hist_rd_s1[SB-1:0] : '0;

	always_ff @(posedge clk) begin
		p_rr_s2 <= tr * hr;
		p_ii_s2 <= ti * hi;
		p_ri_s2 <= tr * hi;
		p_ir_s2 <= ti * hr;
	end

	assign e_rr = EXT_W'(p_rr_s2);
	assign e_ii = EXT_W'(p_ii_s2);
	assign e_ri = EXT_W'(p_ri_s2);
	assign e_ir = EXT_W'(p_ir_s2);

	always_ff @(posedge clk) begin
		if (push) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v_s2) begin
			acc_re_q <= acc_re_q + e_rr[ACC_W-1:0] - e_ii[ACC_W-1:0];
			acc_im_q <= acc_im_q + e_ri[ACC_W-1:0] + e_ir[ACC_W-1:0];
		end
		if (load) begin
			out_re_q  <= acc_re_q;
			out_im_q  <= acc_im_q;
			out_end_q <= (tail_q == '0);
		end
	end

	assign res.valid   = out_valid_q;
	assign res.out_re  = out_re_q;
	assign res.out_im  = out_im_q;
	assign res.run_end = out_end_q;

	assign stat.busy       = (state_q != cdc_pkg::ST_IDLE);
	assign stat.flushing   = (state_q != cdc_pkg::ST_IDLE) && fin_q;
	assign stat.hist_empty = (hcnt_q == '0);
endmodule
`default_nettype wire

@@ rtl/complex_direct_convolution_unit.sv @@
`default_nettype none
// channel   dir  word                                              handshake
// in_ch     in   action tap_index sample_re sample_im is_final     valid/ready
// out_ch    out  out_re out_im run_end                             valid/ready
// apb       in   x_length at byte address 0                        psel/penable
//
// a tap word is written by the back end without leaving idle
// a sample and each tail output of a final sample run the M taps in use
// through the read and product stages; one shared complex mac walks the taps
// a two-word queue lets the input keep accepting while the back end works
// or its result waits; reset clears all taps and the history
module complex_direct_convolution_unit #(
	parameter int MAX_TAPS    = cdc_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = cdc_pkg::SAMPLE_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire [cdc_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire [cdc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [cdc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	cdc_in_if.sink                            in_ch,
	cdc_out_if.source                         out_ch
);
	localparam int QW = $bits(cdc_pkg::cmd_t) + 2 * SAMPLE_BITS;
	localparam int CW = $clog2(MAX_TAPS + 1);

	logic [cdc_pkg::XLEN_W-1:0] x_len_q;
	logic [CW-1:0]              m_eff;
	logic                       push_valid, push_ready, pop_valid, pop_ready;
	logic [QW-1:0]              push_data, pop_data;
	cdc_pkg::back_stat_t        stat;

	assign pready = 1'b1;
	assign prdata = (paddr == cdc_pkg::REG_X_LENGTH)
		? cdc_pkg::APB_DATA_W'(x_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_len_q <= cdc_pkg::XLEN_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr == cdc_pkg::REG_X_LENGTH) begin
			x_len_q <= pwdata[cdc_pkg::XLEN_W-1:0];
		end
	end

	// zero means one tap, too many means all of them
	always_comb begin
		if (x_len_q == '0) begin
			m_eff = CW'(1);
		end else if (int'(x_len_q) > MAX_TAPS) begin
			m_eff = CW'(MAX_TAPS);
		end else begin
			m_eff = CW'(x_len_q);
		end
	end

	cdc_front #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.QW          (QW)
	) u_front (
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	cdc_queue #(
		.WIDTH (QW),
		.DEPTH (cdc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	cdc_back #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.QW          (QW),
		.CW          (CW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.m       (m_eff),
		.q_valid (pop_valid),
		.q_ready (pop_ready),
		.q_data  (pop_data),
		.res     (out_ch),
		.stat    (stat)
	);

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.flushing ##1 !stat.busy) |-> stat.hist_empty)
		else $error("history not empty after flush");

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && !out_ch.run_end) |-> stat.busy)
		else $error("tail word taken with back end idle");

	a_tap_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_eff != '0) && (int'(m_eff) <= MAX_TAPS))
		else $error("tap count out of range");
endmodule
`default_nettype wire
